@@ design/cwmq_pkg.sv @@
// ----------------------------------------------------------------------------
// cwmq_pkg: shared definitions of the character and waiter matching queue
// Widths of the beat fields, result codes, sequencer states and the
// command and status groups between the top level and the character ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwmq_pkg;

    // Default sizes of the two stores.
    localparam int RING_DEPTH_DEF  = 64;
    localparam int MAX_WAITERS_DEF = 8;

    // Field widths of the request and result beats.
    localparam int CHAR_W    = 8;
    localparam int ID_W      = 32;
    localparam int STATUS_W  = 3;
    localparam int CHARS_W   = 6;
    localparam int WAITERS_W = 4;

    // Outcome of one request beat.
    typedef enum logic [STATUS_W-1:0] {
        ST_DELIVERED = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_WAITER    = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_FULL      = 3'd5,
        ST_IGNORED   = 3'd6
    } t_status;

    // Request modes.
    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_WAIT = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH
    } t_state;

    // Commands from the sequencer to the character ring.
    typedef struct packed {
        logic              put;
        logic              take;
        logic [CHAR_W-1:0] data;
    } t_ring_cmd;

    // Status of the character ring, valid before this cycle's command.
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [CHARS_W-1:0] count;
        logic [CHAR_W-1:0]  head_char;
    } t_ring_stat;

endpackage

@@ design/cwmq_req_if.sv @@
// ----------------------------------------------------------------------------
// cwmq_req_if: request channel of the matching queue
// Carries a character arrival or a client wait request with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwmq_req_if
    import cwmq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [CHAR_W-1:0] char_value;
    logic [ID_W-1:0]   waiter_id;

    modport source (output valid, output mode, output char_value, output waiter_id,
                    input ready);
    modport sink   (input valid, input mode, input char_value, input waiter_id,
                    output ready);
endinterface

// ----------------------------------------------------------------------------
// cwmq_rsp_if: result channel of the matching queue
// Carries one result beat per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cwmq_rsp_if
    import cwmq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 delivered;
    logic [ID_W-1:0]      dest_client;
    logic [CHAR_W-1:0]    char_out;
    t_status              status;
    logic [CHARS_W-1:0]   chars_held;
    logic [WAITERS_W-1:0] waiters_held;

    modport source (output valid, output delivered, output dest_client, output char_out,
                    output status, output chars_held, output waiters_held,
                    input ready);
    modport sink   (input valid, input delivered, input dest_client, input char_out,
                    input status, input chars_held, input waiters_held,
                    output ready);
endinterface

@@ design/cwmq_ring.sv @@
// ----------------------------------------------------------------------------
// cwmq_ring: pending character ring
// A circular buffer of characters that keeps one slot unused, so that
// equal pointers mean empty. The oldest character is read from the
// memory into a register every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwmq_ring
    import cwmq_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ring_cmd  i_cmd,
    output t_ring_stat o_stat
);
    localparam int RI = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [RI-1:0] LAST = RI'(RING_DEPTH - 1);

    logic [CHAR_W-1:0] r_mem [RING_DEPTH];
    logic [RI-1:0]     r_rp, r_wp;
    logic [RI-1:0]     n_rp, n_wp;
    logic [CHAR_W-1:0] r_head_char;
    logic [RI-1:0]     w_wp_next;
    logic [RI:0]       w_count;

    // Pointer increments with wrap at the ring depth.
    assign w_wp_next = (r_wp == LAST) ? '0 : r_wp + 1'b1;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_cmd.put) begin
            n_wp = w_wp_next;
        end
        if (i_cmd.take) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
            r_wp <= '0;
        end else begin
            r_rp <= n_rp;
            r_wp <= n_wp;
        end
    end

    // Character memory: one write port, one registered read at the read pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        r_head_char <= r_mem[r_rp];
    end

    // Fill level, reported modulo the width of the result field.
    assign w_count = (r_wp >= r_rp) ? ({1'b0, r_wp} - {1'b0, r_rp})
                                    : ({1'b0, r_wp} + (RI+1)'(RING_DEPTH) - {1'b0, r_rp});

    assign o_stat.empty     = (r_rp == r_wp);
    assign o_stat.full      = (w_wp_next == r_rp);
    assign o_stat.count     = CHARS_W'(w_count);
    assign o_stat.head_char = r_head_char;

endmodule

@@ design/char_waiter_matching_queue_unit.sv @@
// ----------------------------------------------------------------------------
// char_waiter_matching_queue_unit: pairs arriving characters with waiting clients
// A character beat goes to the oldest waiting client, or is queued in the
// character ring, or is dropped when the ring is full. A wait beat with a
// nonzero id takes the oldest queued character, or else joins the waiter
// list once if there is room. Zero characters and zero ids are ignored.
// One request is in flight at a time: a beat is latched, decided in the
// execute state and registered as the result, and a beat that searches the
// waiter list first passes through the search state, in which the single id
// comparator walks the waiter memory one entry per cycle. The next request
// is taken once the previous result is leaving the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_waiter_matching_queue_unit
    import cwmq_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cwmq_req_if.sink   i_req,
    cwmq_rsp_if.source o_rsp
);
    localparam int WI = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int WT = $clog2(MAX_WAITERS + 1);
    localparam logic [WI-1:0] W_LAST = WI'(MAX_WAITERS - 1);
    localparam logic [WT-1:0] W_MAX  = WT'(MAX_WAITERS);

    t_state r_state, n_state;

    // Latched request.
    logic              r_mode;
    logic [CHAR_W-1:0] r_cv;
    logic [ID_W-1:0]   r_id;

    // Waiter list as a circular queue.
    logic [ID_W-1:0] r_wmem [MAX_WAITERS];
    logic [ID_W-1:0] r_wrd;
    logic [WI-1:0]   r_head, n_head;
    logic [WI-1:0]   r_tail, n_tail;
    logic [WT-1:0]   r_total, n_total;
    logic [WI-1:0]   w_raddr;
    logic            w_we;

    // Search walker.
    logic [WI-1:0] r_sptr, n_sptr;
    logic [WT-1:0] r_iss, n_iss;
    logic          r_pend, n_pend;
    logic          w_match;

    // Ring link.
    t_ring_cmd  w_ring_cmd;
    t_ring_stat w_ring_stat;

    // Result register.
    logic                 r_ovalid;
    logic                 r_delivered, n_delivered;
    logic [ID_W-1:0]      r_dest, n_dest;
    logic [CHAR_W-1:0]    r_cout, n_cout;
    t_status              r_status, n_status;
    logic [CHARS_W-1:0]   r_chars, n_chars;
    logic [WAITERS_W-1:0] r_waiters, n_waiters;
    logic                 w_load;
    logic                 w_accept;

    cwmq_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_ring_cmd),
        .o_stat (w_ring_stat)
    );

    // Handshake: one request at a time, taken while the result register drains.
    assign i_req.ready = (r_state == S_IDLE) && (!r_ovalid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    // The single comparator shared by every step of the duplicate search.
    assign w_match = r_pend && (r_wrd == r_id);

    // Sequencer: next state, list updates, ring commands and the result.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_total     = r_total;
        n_sptr      = r_sptr;
        n_iss       = r_iss;
        n_pend      = r_pend;
        w_raddr     = r_head;
        w_we        = 1'b0;
        w_ring_cmd  = '0;
        w_load      = 1'b0;
        n_delivered = 1'b0;
        n_dest      = '0;
        n_cout      = '0;
        n_status    = ST_IGNORED;
        n_chars     = w_ring_stat.count;
        n_waiters   = WAITERS_W'(r_total);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                w_load  = 1'b1;
                if (r_mode == MODE_CHAR) begin
                    if (r_cv == '0) begin
                        n_status = ST_IGNORED;
                    end else if (r_total != '0) begin
                        // The head entry was read while the beat was accepted.
                        n_delivered = 1'b1;
                        n_dest      = r_wrd;
                        n_cout      = r_cv;
                        n_status    = ST_DELIVERED;
                        n_head      = (r_head == W_LAST) ? '0 : r_head + 1'b1;
                        n_total     = r_total - 1'b1;
                        n_waiters   = WAITERS_W'(r_total - 1'b1);
                    end else if (w_ring_stat.full) begin
                        n_status = ST_DROPPED;
                    end else begin
                        w_ring_cmd.put  = 1'b1;
                        w_ring_cmd.data = r_cv;
                        n_status        = ST_QUEUED;
                        n_chars         = w_ring_stat.count + 1'b1;
                    end
                end else if (r_id == '0) begin
                    n_status = ST_IGNORED;
                end else if (!w_ring_stat.empty) begin
                    w_ring_cmd.take = 1'b1;
                    n_delivered     = 1'b1;
                    n_dest          = r_id;
                    n_cout          = w_ring_stat.head_char;
                    n_status        = ST_DELIVERED;
                    n_chars         = w_ring_stat.count - 1'b1;
                end else begin
                    // Start the search: the head entry is already in the read register.
                    w_load  = 1'b0;
                    n_state = S_SRCH;
                    n_pend  = (r_total != '0);
                    n_iss   = (r_total != '0) ? WT'(1) : '0;
                    n_sptr  = (r_head == W_LAST) ? '0 : r_head + 1'b1;
                end
            end
            S_SRCH: begin
                w_raddr = r_sptr;
                if (w_match) begin
                    n_state  = S_IDLE;
                    w_load   = 1'b1;
                    n_status = ST_DUPLICATE;
                end else if ((r_iss == r_total) && !r_pend) begin
                    n_state = S_IDLE;
                    w_load  = 1'b1;
                    if (r_total == W_MAX) begin
                        n_status = ST_FULL;
                    end else begin
                        w_we      = 1'b1;
                        n_tail    = (r_tail == W_LAST) ? '0 : r_tail + 1'b1;
                        n_total   = r_total + 1'b1;
                        n_status  = ST_WAITER;
                        n_waiters = WAITERS_W'(r_total + 1'b1);
                    end
                end else begin
                    n_pend = (r_iss != r_total);
                    if (r_iss != r_total) begin
                        n_iss  = r_iss + 1'b1;
                        n_sptr = (r_sptr == W_LAST) ? '0 : r_sptr + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_total  <= '0;
            r_sptr   <= '0;
            r_iss    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_total <= n_total;
            r_sptr  <= n_sptr;
            r_iss   <= n_iss;
            r_pend  <= n_pend;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_req.mode;
            r_cv   <= i_req.char_value;
            r_id   <= i_req.waiter_id;
        end
    end

    // Waiter memory: append at the tail, registered read at the walker address.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[r_tail] <= r_id;
        end
        r_wrd <= r_wmem[w_raddr];
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_delivered <= n_delivered;
            r_dest      <= n_dest;
            r_cout      <= n_cout;
            r_status    <= n_status;
            r_chars     <= n_chars;
            r_waiters   <= n_waiters;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.delivered    = r_delivered;
    assign o_rsp.dest_client  = r_dest;
    assign o_rsp.char_out     = r_cout;
    assign o_rsp.status       = r_status;
    assign o_rsp.chars_held   = r_chars;
    assign o_rsp.waiters_held = r_waiters;

    // The waiter count never passes the list size.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= W_MAX)
        else $error("waiter count exceeds list size");

    // A pending result is never held while a request is being worked on.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ovalid)
        else $error("result pending during request processing");

    // An accepted request is decided in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // The search walker never issues more reads than there are waiters.
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_iss <= r_total))
        else $error("search walked past the waiter list");

endmodule

@@ tb/cwmq_match_checker.sv @@
// ----------------------------------------------------------------------------
// cwmq_match_checker: result checker of the character and waiter matching queue
// Watches both channels. It keeps its own copy of the character ring and the
// waiter list, works out the result of every accepted request beat, and
// compares each accepted result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwmq_match_checker
    import cwmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cwmq_req_if  i_req,
    cwmq_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_handoffs,
    output int   o_drops,
    output int   o_refusals
);

    // One predicted result beat.
    typedef struct packed {
        logic                 delivered;
        logic [ID_W-1:0]      dest_client;
        logic [CHAR_W-1:0]    char_out;
        t_status              status;
        logic [CHARS_W-1:0]   chars_held;
        logic [WAITERS_W-1:0] waiters_held;
    } t_match;

    // Shadow state: the ring wastes one slot, so pointers wrap at the ring size.
    logic [CHAR_W-1:0]    held_chars [RING_DEPTH_DEF];
    logic [CHARS_W-1:0]   head_idx;
    logic [CHARS_W-1:0]   tail_idx;
    logic [ID_W-1:0]      waiting_ids [MAX_WAITERS_DEF];
    logic [WAITERS_W-1:0] waiting_cnt;
    t_match               outcome_q [$];

    // Apply one request to the shadow state and queue the outcome it should give.
    task automatic predict_match(input logic mode, input logic [CHAR_W-1:0] ch,
                                 input logic [ID_W-1:0] id);
        t_match             m;
        logic               dup;
        logic [CHARS_W-1:0] next_tail;
        m         = '0;
        m.status  = ST_IGNORED;
        dup       = 1'b0;
        next_tail = tail_idx + 1'b1;
        if (mode == MODE_CHAR) begin
            if (ch != '0) begin
                if (waiting_cnt != '0) begin
                    // The oldest waiter gets the character and leaves the list.
                    m.delivered   = 1'b1;
                    m.dest_client = waiting_ids[0];
                    m.char_out    = ch;
                    m.status      = ST_DELIVERED;
                    for (int k = 1; k < MAX_WAITERS_DEF; k++) begin
                        waiting_ids[k-1] = waiting_ids[k];
                    end
                    waiting_cnt = waiting_cnt - 1'b1;
                end else if (next_tail == head_idx) begin
                    m.status = ST_DROPPED;
                end else begin
                    held_chars[tail_idx] = ch;
                    tail_idx             = next_tail;
                    m.status             = ST_QUEUED;
                end
            end
        end else if (id != '0) begin
            if (head_idx != tail_idx) begin
                // A queued character goes to the requester at once.
                m.delivered   = 1'b1;
                m.dest_client = id;
                m.char_out    = held_chars[head_idx];
                m.status      = ST_DELIVERED;
                head_idx      = head_idx + 1'b1;
            end else begin
                for (int k = 0; k < MAX_WAITERS_DEF; k++) begin
                    if (k < waiting_cnt && waiting_ids[k] == id) begin
                        dup = 1'b1;
                    end
                end
                if (dup) begin
                    m.status = ST_DUPLICATE;
                end else if (waiting_cnt >= MAX_WAITERS_DEF) begin
                    m.status = ST_FULL;
                end else begin
                    waiting_ids[waiting_cnt[$clog2(MAX_WAITERS_DEF)-1:0]] = id;
                    waiting_cnt = waiting_cnt + 1'b1;
                    m.status    = ST_WAITER;
                end
            end
        end
        m.chars_held   = tail_idx - head_idx;
        m.waiters_held = waiting_cnt;
        outcome_q.push_back(m);
    endtask

    task automatic check_field(input string label, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    // Result beats are checked before the request beat of the same edge is
    // predicted, since a result always belongs to an earlier request.
    always @(posedge i_clk) begin
        t_match want_m;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH_DEF; k++) begin
                held_chars[k] = '0;
            end
            for (int k = 0; k < MAX_WAITERS_DEF; k++) begin
                waiting_ids[k] = '0;
            end
            head_idx     = '0;
            tail_idx     = '0;
            waiting_cnt  = '0;
            outcome_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_results    = 0;
            o_handoffs   = 0;
            o_drops      = 0;
            o_refusals   = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                o_results++;
                if (outcome_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat with nothing expected, expected none, got status %0d",
                             $time, i_rsp.status);
                end else begin
                    want_m = outcome_q.pop_front();
                    check_field("delivered", ID_W'(want_m.delivered),
                                ID_W'(i_rsp.delivered));
                    check_field("dest_client", want_m.dest_client, i_rsp.dest_client);
                    check_field("char_out", ID_W'(want_m.char_out), ID_W'(i_rsp.char_out));
                    check_field("status", ID_W'(want_m.status), ID_W'(i_rsp.status));
                    check_field("chars_held", ID_W'(want_m.chars_held),
                                ID_W'(i_rsp.chars_held));
                    check_field("waiters_held", ID_W'(want_m.waiters_held),
                                ID_W'(i_rsp.waiters_held));
                    if (want_m.status == ST_DELIVERED) o_handoffs++;
                    if (want_m.status == ST_DROPPED) o_drops++;
                    if (want_m.status == ST_DUPLICATE || want_m.status == ST_FULL) begin
                        o_refusals++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_match(i_req.mode, i_req.char_value, i_req.waiter_id);
            end
            o_pending = outcome_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top of the character and waiter matching queue
// Drives request beats through a directed opening and several random phases
// (mixed traffic, character floods that overrun the ring, wait floods that
// fill the waiter list), stalls the result channel at random, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import cwmq_pkg::*;
();

    logic clk;
    logic rst_n;
    bit   steady;
    int   sent;
    int   fail_count;
    int   pending;
    int   results;
    int   handoffs;
    int   drops;
    int   refusals;

    cwmq_req_if req_ch();
    cwmq_rsp_if rsp_ch();

    char_waiter_matching_queue_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    cwmq_match_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_handoffs   (handoffs),
        .o_drops      (drops),
        .o_refusals   (refusals)
    );

    // 100 MHz clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly nonzero bytes, with zero and the top value now and then.
    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    // Ids come mostly from a small pool so that duplicates happen often.
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 12) return ID_W'($urandom_range(1, 12));
        if (r == 12) return '1;
        return $urandom();
    endfunction

    // Send one request beat after a random gap and wait until it is taken.
    task automatic push_request(input logic mode, input logic [CHAR_W-1:0] ch,
                                input logic [ID_W-1:0] id);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.char_value <= ch;
        req_ch.waiter_id  <= id;
        do @(posedge clk); while (!req_ch.ready);
        sent++;
    endtask

    // Hold off the request side until every outstanding result has come back.
    task automatic settle_queue();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Random traffic; wait_pct sets the share of wait requests.
    task automatic run_mixed(input int beats, input int unsigned wait_pct);
        logic mode;
        for (int n = 0; n < beats; n++) begin
            mode = ($urandom_range(0, 99) < wait_pct) ? MODE_WAIT : MODE_CHAR;
            push_request(mode, pick_char(), pick_id());
        end
    endtask

    // Result side: a random stall before each beat is taken.
    initial begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Stimulus and verdict.
    initial begin
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_CHAR;
        req_ch.char_value = '0;
        req_ch.waiter_id  = '0;
        steady            = 1'b0;
        sent              = 0;
        rst_n             = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: ignored zeros, duplicate, full list, hand-offs both ways.
        push_request(MODE_CHAR, '0, '1);
        push_request(MODE_WAIT, '1, '0);
        push_request(MODE_WAIT, '0, '1);
        push_request(MODE_WAIT, '0, '1);
        for (int n = 1; n < MAX_WAITERS_DEF; n++) begin
            push_request(MODE_WAIT, '0, ID_W'(n));
        end
        push_request(MODE_WAIT, '0, 32'h8000_0000);
        push_request(MODE_CHAR, 8'hFF, '0);
        push_request(MODE_CHAR, 8'h01, '0);
        push_request(MODE_CHAR, 8'h80, '0);
        push_request(MODE_CHAR, 8'h7F, '0);
        push_request(MODE_CHAR, 8'h55, '0);
        push_request(MODE_CHAR, 8'hAA, '0);
        push_request(MODE_CHAR, 8'h10, '0);
        push_request(MODE_CHAR, 8'h02, '0);
        push_request(MODE_CHAR, 8'h01, '0);
        push_request(MODE_WAIT, '0, 32'hA5A5_A5A5);
        push_request(MODE_WAIT, '0, '1);
        push_request(MODE_CHAR, 8'hFE, '0);
        settle_queue();

        // Balanced random traffic.
        run_mixed(120, 50);
        settle_queue();

        // Character flood without gaps: overruns the ring and drops.
        steady = 1'b1;
        run_mixed(80, 0);
        steady = 1'b0;
        settle_queue();

        // Wait flood: drains the ring, then fills the waiter list.
        run_mixed(80, 100);
        settle_queue();

        // Lopsided random traffic in both directions.
        run_mixed(70, 75);
        run_mixed(70, 25);

        settle_queue();
        repeat (12) @(posedge clk);
        $display("tb: %0d request beats sent, %0d result beats checked", sent, results);
        $display("tb: %0d hand-offs, %0d drops, %0d duplicate or full-list refusals",
                 handoffs, drops, refusals);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
